@@ src/bhdsnr_pkg.sv @@
// Package for the BPSK hard-decision SNR check block.
// Holds the sizing constants, the frame record type and the queue status type.
// Depends on nothing; every module of the block imports it.
package bhdsnr_pkg;

  // Longest frame; a sample that brings the count to this value closes the frame.
  localparam int MAX_SYMBOLS = 4096;

  localparam int SAMPLE_W = 16;
  localparam int LOG_MAX  = $clog2(MAX_SYMBOLS);
  localparam int COUNT_W  = $clog2(MAX_SYMBOLS + 1);

  // Correlation sums reach +MAX_SYMBOLS * 2^15, so one extra bit above the magnitude.
  localparam int CORR_W   = LOG_MAX + SAMPLE_W + 1;
  localparam int MAG_W    = CORR_W - 1;
  localparam int ENERGY_W = LOG_MAX + 2 * SAMPLE_W;

  // Width of |C|^2, n*E and the residual.
  localparam int POW_W    = 2 * MAG_W + 1;

  // Threshold register, unsigned Q8.8.
  localparam int THR_W         = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd256;
  localparam int SCALE_SHIFT   = 8;

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Stream data widths.
  localparam int IN_DATA_W  = 2 * SAMPLE_W;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 * SAMPLE_W - 2;

  // One accepted sample with the running sums that include it.
  typedef struct packed {
    logic                       decided;
    logic                       last;
    logic signed [CORR_W-1:0]   corr_re;
    logic signed [CORR_W-1:0]   corr_im;
    logic        [ENERGY_W-1:0] energy;
    logic        [COUNT_W-1:0]  count;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

@@ src/bhdsnr_front.sv @@
// Front part: accepts samples, makes the hard decision and keeps the frame sums.
// Pushes one record per sample into the queue. Depends on bhdsnr_pkg.
module bhdsnr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata fields from bit 0 up: sample_re[15:0], sample_im[15:0]
  input  logic [bhdsnr_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                             s_tlast,
  input  bhdsnr_pkg::fifo_status_t         fifo_status,
  output logic                             push,
  output bhdsnr_pkg::frame_rec_t           push_rec
);
  import bhdsnr_pkg::*;

  logic signed [SAMPLE_W-1:0]   re;
  logic signed [SAMPLE_W-1:0]   im;
  logic                         decided;
  logic signed [2*SAMPLE_W-1:0] sq_re;
  logic signed [2*SAMPLE_W-1:0] sq_im;
  logic                         last;

  logic        [COUNT_W-1:0]    symbol_count;
  logic signed [CORR_W-1:0]     corr_re_acc;
  logic signed [CORR_W-1:0]     corr_im_acc;
  logic        [ENERGY_W-1:0]   energy_acc;

  logic        [COUNT_W-1:0]    symbol_count_next;
  logic signed [CORR_W-1:0]     corr_re_next;
  logic signed [CORR_W-1:0]     corr_im_next;
  logic        [ENERGY_W-1:0]   energy_next;

  assign re = s_tdata[SAMPLE_W-1:0];
  assign im = s_tdata[2*SAMPLE_W-1:SAMPLE_W];

  // A non-negative real part decides bit 1.
  assign decided = ~re[SAMPLE_W-1];

  // Sums including the current sample.
  assign sq_re = re * re;
  assign sq_im = im * im;
  assign corr_re_next = decided ? corr_re_acc + CORR_W'(re) : corr_re_acc - CORR_W'(re);
  assign corr_im_next = decided ? corr_im_acc + CORR_W'(im) : corr_im_acc - CORR_W'(im);
  assign energy_next  = energy_acc + ENERGY_W'($unsigned(sq_re))
                                   + ENERGY_W'($unsigned(sq_im));
  assign symbol_count_next = symbol_count + 1'b1;

  // A frame also closes when it reaches the maximum length.
  assign last = s_tlast || (symbol_count_next == COUNT_W'(MAX_SYMBOLS));

  // Take a sample whenever the queue has room.
  assign s_tready = ~fifo_status.full;
  assign push     = s_tvalid & s_tready;

  always_comb begin
    push_rec.decided = decided;
    push_rec.last    = last;
    push_rec.corr_re = corr_re_next;
    push_rec.corr_im = corr_im_next;
    push_rec.energy  = energy_next;
    push_rec.count   = symbol_count_next;
  end

  // Frame sums, cleared after the last sample of a frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      corr_re_acc  <= '0;
      corr_im_acc  <= '0;
      energy_acc   <= '0;
    end else if (push) begin
      if (last) begin
        symbol_count <= '0;
        corr_re_acc  <= '0;
        corr_im_acc  <= '0;
        energy_acc   <= '0;
      end else begin
        symbol_count <= symbol_count_next;
        corr_re_acc  <= corr_re_next;
        corr_im_acc  <= corr_im_next;
        energy_acc   <= energy_next;
      end
    end
  end

endmodule

@@ src/bhdsnr_fifo.sv @@
// Short queue of frame records between the front and the back part.
// Register based, one push and one pop per cycle. Depends on bhdsnr_pkg.
module bhdsnr_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  bhdsnr_pkg::frame_rec_t   push_rec,
  input  logic                     pop,
  output bhdsnr_pkg::frame_rec_t   pop_rec,
  output bhdsnr_pkg::fifo_status_t status
);
  import bhdsnr_pkg::*;

  frame_rec_t         entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;

  assign pop_rec      = entries[rd_ptr];
  assign status.full  = (fill == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign status.empty = (fill == '0);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

@@ src/bhdsnr_back.sv @@
// Back part: drains the queue, works out gain and the SINR test at frame ends,
// and holds the output register. Depends on bhdsnr_pkg.
module bhdsnr_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [bhdsnr_pkg::THR_W-1:0]      cfg_wr_data,
  input  bhdsnr_pkg::fifo_status_t          fifo_status,
  input  bhdsnr_pkg::frame_rec_t            pop_rec,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata fields from bit 0 up: decided_bit, gain_re[15:0], gain_im[15:0], decode_ok
  output logic [bhdsnr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                              m_tlast
);
  import bhdsnr_pkg::*;

  localparam int E_LO_W    = ENERGY_W / 2;
  localparam int E_HI_W    = ENERGY_W - E_LO_W;
  localparam int R_LO_W    = POW_W / 2;
  localparam int R_HI_W    = POW_W - R_LO_W;
  localparam int TR_W      = THR_W + POW_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int DIV_CNT_W = $clog2(MAG_W);
  localparam int GAIN_MAX  = 2 ** (SAMPLE_W - 1) - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_RE, S_SQ_IM, S_NE_LO, S_NE_HI, S_RES,
    S_TR_LO, S_TR_HI, S_CMP, S_DIV, S_OUT
  } state_t;

  state_t                 state;
  logic [THR_W-1:0]       threshold;
  logic                   out_free;
  logic                   out_load;

  logic                   decided;
  logic [COUNT_W-1:0]     n_reg;
  logic [ENERGY_W-1:0]    energy;
  logic [MAG_W-1:0]       mag_re;
  logic [MAG_W-1:0]       mag_im;
  logic                   neg_re;
  logic                   neg_im;
  logic [POW_W-1:0]       s_pow;
  logic [POW_W-1:0]       ne_pow;
  logic [POW_W-1:0]       res_pow;
  logic [TR_W-1:0]        tr;
  logic                   ok;
  logic [MAG_W-1:0]       div_re;
  logic [MAG_W-1:0]       div_im;
  logic [COUNT_W-1:0]     rem_re;
  logic [COUNT_W-1:0]     rem_im;
  logic [DIV_CNT_W-1:0]   div_cnt;

  logic [MAG_W-1:0]            sq_op;
  logic [SQ_W-1:0]             sq_prod;
  logic [E_HI_W-1:0]           ne_op;
  logic [COUNT_W+E_HI_W-1:0]   ne_prod;
  logic [R_HI_W-1:0]           tr_op;
  logic [THR_W+R_HI_W-1:0]     tr_prod;
  logic [COUNT_W:0]            sh_re;
  logic [COUNT_W:0]            sh_im;
  logic [COUNT_W:0]            diff_re;
  logic [COUNT_W:0]            diff_im;
  logic                        ge_re;
  logic                        ge_im;

  // Magnitude of a correlation sum.
  function automatic logic [MAG_W-1:0] mag_of(input logic signed [CORR_W-1:0] x);
    logic signed [CORR_W-1:0] negated;
    negated = -x;
    return x[CORR_W-1] ? negated[MAG_W-1:0] : x[MAG_W-1:0];
  endfunction

  // Apply the sign to a truncated quotient and saturate to the sample range.
  function automatic logic [SAMPLE_W-1:0] sat_gain(input logic [MAG_W-1:0] q,
                                                   input logic neg);
    logic [SAMPLE_W-1:0] result;
    if (!neg) begin
      result = (q > MAG_W'(GAIN_MAX)) ? SAMPLE_W'(GAIN_MAX) : q[SAMPLE_W-1:0];
    end else if (q > MAG_W'(GAIN_MAX + 1)) begin
      result = SAMPLE_W'(GAIN_MAX + 1);
    end else begin
      result = ~q[SAMPLE_W-1:0] + 1'b1;
    end
    return result;
  endfunction

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  assign out_free = ~m_tvalid | m_tready;
  assign pop      = (state == S_IDLE) && !fifo_status.empty && out_free;

  // A word is loaded for an ordinary sample or once a summary is ready.
  assign out_load = (pop && !pop_rec.last) || ((state == S_OUT) && out_free);

  // Shared multipliers; each operand is chosen by the step in progress.
  assign sq_op   = (state == S_SQ_RE) ? mag_re : mag_im;
  assign sq_prod = sq_op * sq_op;
  assign ne_op   = (state == S_NE_LO) ? E_HI_W'(energy[E_LO_W-1:0])
                                      : energy[ENERGY_W-1:E_LO_W];
  assign ne_prod = n_reg * ne_op;
  assign tr_op   = (state == S_TR_LO) ? R_HI_W'(res_pow[R_LO_W-1:0])
                                      : res_pow[POW_W-1:R_LO_W];
  assign tr_prod = threshold * tr_op;

  // One restoring division step for each gain part.
  assign sh_re   = {rem_re, div_re[MAG_W-1]};
  assign sh_im   = {rem_im, div_im[MAG_W-1]};
  assign diff_re = sh_re - {1'b0, n_reg};
  assign diff_im = sh_im - {1'b0, n_reg};
  assign ge_re   = (sh_re >= {1'b0, n_reg});
  assign ge_im   = (sh_im >= {1'b0, n_reg});

  // Sequencer, working registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (pop_rec.last) begin
              decided <= pop_rec.decided;
              n_reg   <= pop_rec.count;
              energy  <= pop_rec.energy;
              mag_re  <= mag_of(pop_rec.corr_re);
              mag_im  <= mag_of(pop_rec.corr_im);
              neg_re  <= pop_rec.corr_re[CORR_W-1];
              neg_im  <= pop_rec.corr_im[CORR_W-1];
              state   <= S_SQ_RE;
            end else begin
              m_tlast  <= 1'b0;
              m_tdata  <= OUT_DATA_W'(pop_rec.decided);
            end
          end
        end
        S_SQ_RE: begin
          s_pow <= POW_W'(sq_prod);
          state <= S_SQ_IM;
        end
        S_SQ_IM: begin
          s_pow <= s_pow + POW_W'(sq_prod);
          state <= S_NE_LO;
        end
        S_NE_LO: begin
          ne_pow <= POW_W'(ne_prod);
          state  <= S_NE_HI;
        end
        S_NE_HI: begin
          ne_pow <= ne_pow + (POW_W'(ne_prod) << E_LO_W);
          state  <= S_RES;
        end
        S_RES: begin
          res_pow <= ne_pow - s_pow;
          state   <= S_TR_LO;
        end
        S_TR_LO: begin
          tr    <= TR_W'(tr_prod);
          state <= S_TR_HI;
        end
        S_TR_HI: begin
          tr    <= tr + (TR_W'(tr_prod) << R_LO_W);
          state <= S_CMP;
        end
        S_CMP: begin
          // A zero residual always passes.
          ok      <= (res_pow == '0) || ((TR_W'(s_pow) << SCALE_SHIFT) >= tr);
          div_re  <= mag_re;
          div_im  <= mag_im;
          rem_re  <= '0;
          rem_im  <= '0;
          div_cnt <= DIV_CNT_W'(MAG_W - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          rem_re <= ge_re ? diff_re[COUNT_W-1:0] : sh_re[COUNT_W-1:0];
          rem_im <= ge_im ? diff_im[COUNT_W-1:0] : sh_im[COUNT_W-1:0];
          div_re <= {div_re[MAG_W-2:0], ge_re};
          div_im <= {div_im[MAG_W-2:0], ge_im};
          if (div_cnt == '0) begin
            state <= S_OUT;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tlast  <= 1'b1;
            m_tdata  <= {{OUT_PAD_W{1'b0}}, ok, sat_gain(div_im, neg_im),
                         sat_gain(div_re, neg_re), decided};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/bpsk_hard_decision_snr_check_core.sv @@
// Top level of the BPSK hard-decision receiver with gain and SINR check.
// Instantiates bhdsnr_front, bhdsnr_fifo and bhdsnr_back; depends on bhdsnr_pkg.
//
// Usage:
// Samples enter on the s_ stream: s_tdata carries the real and imaginary
// parts, s_tlast marks the last sample of a frame. Every sample gives one
// result word on the m_ stream with its hard decision; the word that closes
// a frame has m_tlast high and carries the gain estimate and the decode flag.
// A frame also closes on its own at the maximum frame length.
// Ordinary samples pass the queue entry and the output register and flow
// at one word per cycle while the back part is idle and m_tready is high.
// A frame-closing sample runs the back part through six multiply steps,
// a subtraction and a comparison, then a 28-step divider for the gain.
// The four-entry queue keeps taking samples while the summary is worked
// out, and s_tready falls when it is full. A stall on m_tready holds the
// output word and fills the queue in the same way. Reset empties the queue,
// clears the frame sums and sets the threshold to 1.0 in Q8.8; cfg_wr_en
// writes a new threshold.
module bpsk_hard_decision_snr_check_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata fields from bit 0 up: sample_re[15:0], sample_im[15:0]
  input  logic [bhdsnr_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata fields from bit 0 up: decided_bit, gain_re[15:0], gain_im[15:0], decode_ok
  output logic [bhdsnr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_wr_en,
  input  logic [bhdsnr_pkg::THR_W-1:0]      cfg_wr_data
);
  import bhdsnr_pkg::*;

  logic         push;
  logic         pop;
  frame_rec_t   push_rec;
  frame_rec_t   pop_rec;
  fifo_status_t fifo_status;

  // Sample intake and frame sums.
  bhdsnr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .fifo_status (fifo_status),
    .push        (push),
    .push_rec    (push_rec)
  );

  // Queue between the two parts.
  bhdsnr_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .status   (fifo_status)
  );

  // Summary computation and result output.
  bhdsnr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fifo_status (fifo_status),
    .pop_rec     (pop_rec),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule
